### rtl/core/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// Types, command codes and calendar helpers for the Gregorian date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DOY_W    = 9;
    localparam int PACKED_W = 28;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_LAST = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_LAST   = DAY_W'(31);

    // y / 25 as (y * Div25Mul) >> Div25Shift, exact for 14-bit years
    localparam int Div25Mul   = 5243;
    localparam int Div25Shift = 17;

    typedef enum logic [2:0] {
        CMD_QUERY    = 3'd0,
        CMD_LOAD_YMD = 3'd1,
        CMD_LOAD_DOY = 3'd2,
        CMD_NEXT     = 3'd3,
        CMD_PREV     = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [DOY_W-1:0]   in_day_of_year;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]          out_year;
        logic [MONTH_W-1:0]         out_month;
        logic [DAY_W-1:0]           out_day;
        logic [DOY_W-1:0]           out_day_of_year;
        logic                       date_valid;
        logic                       leap_year;
        logic                       first_day;
        logic                       last_day;
        logic                       load_error;
        logic signed [PACKED_W-1:0] packed_date;
    } res_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [27:0]       prod;
        logic [YEAR_W-1:0] quot;
        logic [YEAR_W-1:0] back;
        logic              div25;
        prod  = 28'(y) * 28'(Div25Mul);
        quot  = YEAR_W'(prod >> Div25Shift);
        back  = YEAR_W'(quot * YEAR_W'(25));
        div25 = (back == y);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
            4'd2:                                      len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                   len = '0;
        endcase
        return len;
    endfunction

    // first day of year of each month in a common year
    function automatic logic [DOY_W-1:0] month_first(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] st;
        case (m)
            4'd1:    st = DOY_W'(1);
            4'd2:    st = DOY_W'(32);
            4'd3:    st = DOY_W'(60);
            4'd4:    st = DOY_W'(91);
            4'd5:    st = DOY_W'(121);
            4'd6:    st = DOY_W'(152);
            4'd7:    st = DOY_W'(182);
            4'd8:    st = DOY_W'(213);
            4'd9:    st = DOY_W'(244);
            4'd10:   st = DOY_W'(274);
            4'd11:   st = DOY_W'(305);
            4'd12:   st = DOY_W'(335);
            default: st = '0;
        endcase
        return st;
    endfunction

endpackage

### rtl/core/gdc_calc.sv
// ----------------------------------------------------------------------------
// gdc_calc
// Next stored date and result fields for one request, from the current date.
// ----------------------------------------------------------------------------
module gdc_calc
    import gdc_pkg::*;
(
    input  req_t  req,
    input  date_t cur,
    output date_t nxt,
    output res_t  res
);

    logic               cur_leap;
    logic               cur_ok;
    logic [DAY_W-1:0]   cur_dim;
    logic [DAY_W-1:0]   prev_dim;
    logic               in_leap;
    logic               doy_found;
    date_t              doy_date;
    logic [DOY_W-1:0]   st;
    logic [DOY_W-1:0]   len;
    logic               err;
    logic               nxt_leap;
    logic               nxt_ok;
    logic [DOY_W-1:0]   doy;
    logic [PACKED_W-1:0] pack_sum;

    assign cur_leap = is_leap(cur.year);
    assign cur_dim  = days_in(cur_leap, cur.month);
    assign prev_dim = days_in(cur_leap, cur.month - MONTH_W'(1));
    assign cur_ok   = (cur.year <= YEAR_MAX) && (cur.month >= MONTH_W'(1))
                    && (cur.month <= MONTH_LAST) && (cur.day >= DAY_W'(1))
                    && (cur.day <= cur_dim);
    assign in_leap  = is_leap(req.in_year);

    // month search for day-of-year load, month ranges are disjoint
    always_comb
    begin
        doy_found = 1'b0;
        doy_date  = '0;
        st        = '0;
        len       = '0;
        for (int i = 1; i <= 12; i++)
        begin
            st  = month_first(MONTH_W'(i))
                + DOY_W'((in_leap && (i >= 3)) ? 1 : 0);
            len = DOY_W'(days_in(in_leap, MONTH_W'(i)));
            if ((req.in_day_of_year >= st) && (req.in_day_of_year < st + len))
            begin
                doy_found      = 1'b1;
                doy_date.year  = req.in_year;
                doy_date.month = MONTH_W'(i);
                doy_date.day   = DAY_W'(req.in_day_of_year - st + DOY_W'(1));
            end
        end
    end

    always_comb
    begin
        nxt = cur;
        err = 1'b0;
        unique case (req.command)
            CMD_LOAD_YMD:
            begin
                nxt.year  = req.in_year;
                nxt.month = req.in_month;
                nxt.day   = req.in_day;
            end
            CMD_LOAD_DOY:
            begin
                if (doy_found)
                    nxt = doy_date;
                else
                    err = 1'b1;
            end
            CMD_NEXT:
            begin
                if (!cur_ok)
                    nxt = '0;
                else if (cur.day < cur_dim)
                    nxt.day = cur.day + DAY_W'(1);
                else if (cur.month < MONTH_LAST)
                begin
                    nxt.month = cur.month + MONTH_W'(1);
                    nxt.day   = DAY_W'(1);
                end
                else if (cur.year < YEAR_MAX)
                begin
                    nxt.year  = cur.year + YEAR_W'(1);
                    nxt.month = MONTH_W'(1);
                    nxt.day   = DAY_W'(1);
                end
                else
                    err = 1'b1;
            end
            CMD_PREV:
            begin
                if (!cur_ok)
                    nxt = '0;
                else if (cur.day > DAY_W'(1))
                    nxt.day = cur.day - DAY_W'(1);
                else if (cur.month > MONTH_W'(1))
                begin
                    nxt.month = cur.month - MONTH_W'(1);
                    nxt.day   = prev_dim;
                end
                else if (cur.year > YEAR_W'(0))
                begin
                    nxt.year  = cur.year - YEAR_W'(1);
                    nxt.month = MONTH_LAST;
                    nxt.day   = DAY_LAST;
                end
                else
                    err = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign nxt_leap = is_leap(nxt.year);
    assign nxt_ok   = (nxt.year <= YEAR_MAX) && (nxt.month >= MONTH_W'(1))
                    && (nxt.month <= MONTH_LAST) && (nxt.day >= DAY_W'(1))
                    && (nxt.day <= days_in(nxt_leap, nxt.month));
    assign doy      = month_first(nxt.month) + DOY_W'(nxt.day) - DOY_W'(1)
                    + DOY_W'((nxt_leap && (nxt.month > MONTH_W'(2))) ? 1 : 0);
    assign pack_sum = PACKED_W'(nxt.year) * PACKED_W'(10000)
                    + PACKED_W'(nxt.month) * PACKED_W'(100)
                    + PACKED_W'(nxt.day);

    always_comb
    begin
        res.out_year        = nxt.year;
        res.out_month       = nxt.month;
        res.out_day         = nxt.day;
        res.out_day_of_year = nxt_ok ? doy : '0;
        res.date_valid      = nxt_ok;
        res.leap_year       = nxt_leap;
        res.first_day       = (nxt.month == MONTH_W'(1)) && (nxt.day == DAY_W'(1));
        res.last_day        = (nxt.month == MONTH_LAST) && (nxt.day == DAY_LAST);
        res.load_error      = err;
        res.packed_date     = nxt_ok ? signed'(pack_sum) : '1;
    end

endmodule

### rtl/core/gregorian_date_counter.sv
// ----------------------------------------------------------------------------
// gregorian_date_counter
// Holds a Gregorian date and applies one command per request.
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall / req, taken when valid and not stall
//   result channel:  res_valid / res_stall / res, one result per request
//   commands: query, load year-month-day, load year plus day of year,
//   next day, previous day; each result describes the date after the command
// flow
//   a taken request is loaded into the input register and its result into the
//   result register once that register is free or its result is being taken
// throughput
//   one request per cycle while res_stall is low; the date update and result
//   fields settle in a single pass of logic from input register to result register
// reset
//   stored date clears to the zero date (invalid), both registers empty
// stall
//   a waiting result holds; the input register still takes one request,
//   then req_stall rises until the result is taken
// ----------------------------------------------------------------------------
module gregorian_date_counter
    import gdc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic  in_valid_reg;
    logic  in_valid_next;
    req_t  in_reg;
    date_t date_reg;
    date_t date_next;
    logic  res_valid_reg;
    logic  res_valid_next;
    res_t  res_reg;
    res_t  res_next;
    logic  advance;

    assign advance   = in_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = in_valid_reg && !advance;

    assign in_valid_next  = req_stall ? in_valid_reg : req_valid;
    assign res_valid_next = advance ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);

    gdc_calc u_calc (
        .req (in_reg),
        .cur (date_reg),
        .nxt (date_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            date_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
                date_reg <= date_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_reg <= req;
        if (advance)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Gregorian date counter. A directed table walks
// the year and month edges, day-of-year errors, leap rules, out-of-range and
// invalid dates. A random phase of load/step sequences follows. Every result
// is checked field by field against typed row values or a calendar predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import gdc_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_PCT     = 19;
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 40;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct {
        req_t rq;
        bit   typed;
        res_t want;
    } row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    logic [YEAR_W-1:0]  cal_year  = '0;
    logic [MONTH_W-1:0] cal_month = '0;
    logic [DAY_W-1:0]   cal_day   = '0;
    bit                 walk_back = 1'b0;

    res_t dates_due[$];
    row_t plan[$];
    int   taken_requests = 0;
    int   seen_results   = 0;
    int   fail_count     = 0;

    gregorian_date_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit leap_of(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_of(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_ok(input int unsigned y, input int unsigned m,
                                   input int unsigned d);
        return (y <= YEAR_MAX) && (month_days(y, m) != 0) && (d >= 1)
            && (d <= month_days(y, m));
    endfunction

    function automatic res_t apply_date_command(input req_t rq);
        res_t        r;
        bit          fail;
        bit          ok;
        int unsigned y;
        int unsigned m;
        int unsigned rem;
        int unsigned doy;
        fail = 1'b0;
        case (rq.command) inside
            CMD_LOAD_YMD:
            begin
                cal_year  = rq.in_year;
                cal_month = rq.in_month;
                cal_day   = rq.in_day;
            end
            CMD_LOAD_DOY:
            begin
                y   = rq.in_year;
                rem = rq.in_day_of_year;
                if (rem == 0 || rem > (leap_of(y) ? 366 : 365))
                    fail = 1'b1;
                else
                begin
                    m = 1;
                    while (rem > month_days(y, m))
                    begin
                        rem = rem - month_days(y, m);
                        m++;
                    end
                    cal_year  = YEAR_W'(y);
                    cal_month = MONTH_W'(m);
                    cal_day   = DAY_W'(rem);
                end
            end
            CMD_NEXT, CMD_PREV:
            begin
                if (!date_ok(cal_year, cal_month, cal_day))
                begin
                    cal_year  = '0;
                    cal_month = '0;
                    cal_day   = '0;
                end
                else if (rq.command == CMD_NEXT)
                begin
                    if (cal_day < month_days(cal_year, cal_month))
                        cal_day++;
                    else if (cal_month < MONTH_LAST)
                    begin
                        cal_month++;
                        cal_day = 1;
                    end
                    else if (cal_year < YEAR_MAX)
                    begin
                        cal_year++;
                        cal_month = 1;
                        cal_day   = 1;
                    end
                    else
                        fail = 1'b1;
                end
                else
                begin
                    if (cal_day > 1)
                        cal_day--;
                    else if (cal_month > 1)
                    begin
                        cal_month--;
                        cal_day = DAY_W'(month_days(cal_year, cal_month));
                    end
                    else if (cal_year > 0)
                    begin
                        cal_year--;
                        cal_month = MONTH_LAST;
                        cal_day   = DAY_LAST;
                    end
                    else
                        fail = 1'b1;
                end
            end
            default: ;
        endcase

        ok  = date_ok(cal_year, cal_month, cal_day);
        doy = 0;
        if (ok)
        begin
            doy = cal_day;
            for (m = 1; m < cal_month; m++)
                doy = doy + month_days(cal_year, m);
        end
        r.out_year        = cal_year;
        r.out_month       = cal_month;
        r.out_day         = cal_day;
        r.out_day_of_year = DOY_W'(doy);
        r.date_valid      = ok;
        r.leap_year       = leap_of(cal_year);
        r.first_day       = (cal_month == 1) && (cal_day == 1);
        r.last_day        = (cal_month == MONTH_LAST) && (cal_day == DAY_LAST);
        r.load_error      = fail;
        r.packed_date     = ok ? PACKED_W'(int'(cal_year) * 10000 + int'(cal_month) * 100
                                           + int'(cal_day)) : '1;
        return r;
    endfunction

    function automatic req_t mk_req(input logic [2:0] c, input int y, input int m,
                                    input int d, input int doy);
        req_t rq;
        rq.command        = c;
        rq.in_year        = YEAR_W'(y);
        rq.in_month       = MONTH_W'(m);
        rq.in_day         = DAY_W'(d);
        rq.in_day_of_year = DOY_W'(doy);
        return rq;
    endfunction

    function automatic res_t mk_res(input int y, input int m, input int d, input int doy,
                                    input bit v, input bit lp, input bit fd, input bit ld,
                                    input bit er, input int pk);
        res_t r;
        r.out_year        = YEAR_W'(y);
        r.out_month       = MONTH_W'(m);
        r.out_day         = DAY_W'(d);
        r.out_day_of_year = DOY_W'(doy);
        r.date_valid      = v;
        r.leap_year       = lp;
        r.first_day       = fd;
        r.last_day        = ld;
        r.load_error      = er;
        r.packed_date     = PACKED_W'(pk);
        return r;
    endfunction

    function automatic int unsigned pick_year();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(YEAR_MAX - 3, YEAR_MAX);
            2:       return $urandom_range(0, 99) * 100;
            3:       return $urandom_range(0, 2499) * 4;
            default: return $urandom_range(0, YEAR_MAX);
        endcase
    endfunction

    // mostly loads near month and year edges followed by walks across them
    function automatic req_t pick_request();
        req_t        rq;
        int unsigned sel;
        int unsigned y;
        int unsigned m;
        int unsigned len;
        rq.command        = CMD_QUERY;
        rq.in_year        = YEAR_W'($urandom);
        rq.in_month       = MONTH_W'($urandom);
        rq.in_day         = DAY_W'($urandom);
        rq.in_day_of_year = DOY_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            if ($urandom_range(0, 9) == 0)
                walk_back = !walk_back;
            rq.command = walk_back ? CMD_PREV : CMD_NEXT;
        end
        else if (sel < 60)
        begin
            y = pick_year();
            m = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? MONTH_LAST : 1)
                                            : $urandom_range(1, MONTH_LAST);
            len = month_days(y, m);
            rq.command  = CMD_LOAD_YMD;
            rq.in_year  = YEAR_W'(y);
            rq.in_month = MONTH_W'(m);
            case ($urandom_range(0, 2))
                0:       rq.in_day = DAY_W'(1);
                1:       rq.in_day = DAY_W'(len - $urandom_range(0, 1));
                default: rq.in_day = DAY_W'($urandom_range(1, len));
            endcase
        end
        else if (sel < 70)
        begin
            y   = pick_year();
            len = leap_of(y) ? 366 : 365;
            rq.command = CMD_LOAD_DOY;
            rq.in_year = YEAR_W'(y);
            case ($urandom_range(0, 3))
                0:       rq.in_day_of_year = DOY_W'($urandom_range(1, 2));
                1:       rq.in_day_of_year = DOY_W'(len - $urandom_range(0, 1));
                2:       rq.in_day_of_year = DOY_W'($urandom_range(58, 61));
                default: rq.in_day_of_year = DOY_W'($urandom_range(1, len));
            endcase
        end
        else if (sel < 80)
            rq.command = CMD_LOAD_YMD;
        else if (sel < 85)
        begin
            rq.command = CMD_LOAD_DOY;
            if ($urandom_range(0, 1))
                rq.in_day_of_year = DOY_W'($urandom_range(360, 370));
        end
        else if (sel < 95)
            rq.command = CMD_QUERY;
        else
            rq.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        return rq;
    endfunction

    task automatic log_fail(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_fail($sformatf("result %0d %s: got %0d want %0d",
                               seen_results, name, got, want));
    endtask

    task automatic take_result(input res_t r);
        res_t want;
        if (dates_due.size() == 0)
            log_fail("result with no request pending");
        else
        begin
            want = dates_due.pop_front();
            check_field("out_year", 32'(r.out_year), 32'(want.out_year));
            check_field("out_month", 32'(r.out_month), 32'(want.out_month));
            check_field("out_day", 32'(r.out_day), 32'(want.out_day));
            check_field("out_day_of_year", 32'(r.out_day_of_year),
                        32'(want.out_day_of_year));
            check_field("date_valid", 32'(r.date_valid), 32'(want.date_valid));
            check_field("leap_year", 32'(r.leap_year), 32'(want.leap_year));
            check_field("first_day", 32'(r.first_day), 32'(want.first_day));
            check_field("last_day", 32'(r.last_day), 32'(want.last_day));
            check_field("load_error", 32'(r.load_error), 32'(want.load_error));
            check_field("packed_date", 32'(r.packed_date), 32'(want.packed_date));
        end
        seen_results++;
    endtask

    task automatic send_request(input req_t item, input bit typed, input res_t want);
        res_t predicted;
        while (!(taken_requests >= 400 && taken_requests < 600)
               && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_date_command(item);
        dates_due.push_back(typed ? want : predicted);
        taken_requests++;
    endtask

    task automatic add_row(input req_t rq, input bit typed, input res_t want);
        row_t row;
        row.rq    = rq;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    initial
    begin
        add_row(mk_req(CMD_QUERY, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 1, 0, 0, 0, -1));
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 1, 0, 0, 0, -1));
        add_row(mk_req(CMD_LOAD_YMD, 9999, 12, 31, 0), 1'b1,
                mk_res(9999, 12, 31, 365, 1, 0, 0, 1, 0, 99991231));
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0), 1'b1,
                mk_res(9999, 12, 31, 365, 1, 0, 0, 1, 1, 99991231));
        add_row(mk_req(CMD_LOAD_YMD, 0, 1, 1, 0), 1'b1, mk_res(0, 1, 1, 1, 1, 1, 1, 0, 0, 101));
        add_row(mk_req(CMD_PREV, 0, 0, 0, 0), 1'b1, mk_res(0, 1, 1, 1, 1, 1, 1, 0, 1, 101));
        add_row(mk_req(CMD_LOAD_DOY, 2000, 0, 0, 366), 1'b1,
                mk_res(2000, 12, 31, 366, 1, 1, 0, 1, 0, 20001231));
        add_row(mk_req(CMD_LOAD_DOY, 1900, 0, 0, 366), 1'b1,
                mk_res(2000, 12, 31, 366, 1, 1, 0, 1, 1, 20001231));
        add_row(mk_req(CMD_LOAD_DOY, 2024, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_DOY, 2023, 0, 0, 511), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_DOY, 2024, 0, 0, 60), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_PREV, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_YMD, 2023, 2, 28, 0), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_YMD, 2100, 2, 29, 0), 1'b0, '0);
        add_row(mk_req(CMD_PREV, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_YMD, 16383, 15, 31, 511), 1'b0, '0);
        add_row(mk_req(CMD_SPARE_LAST, 16383, 15, 31, 511), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_YMD, 12000, 1, 1, 0), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_DOY, 16383, 0, 0, 100), 1'b0, '0);
        add_row(mk_req(CMD_LOAD_YMD, 1999, 12, 31, 0), 1'b0, '0);
        add_row(mk_req(CMD_NEXT, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(CMD_PREV, 0, 0, 0, 0), 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].rq, plan[i].typed, plan[i].want);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_request(pick_request(), 1'b0, '0);
        req_valid <= 1'b0;

        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dates_due.size() != 0)
            log_fail($sformatf("%0d results never arrived", dates_due.size()));
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                take_result(res);
            if (seen_results == HOLD_AT && !held)
            begin
                held = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seen_results >= 400 && seen_results < 600)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
